// ===== rtl/core/srhv_pkg.sv =====
// Shared types, constants and helper functions for the signed record header validator.
// No dependencies; every other file of the block except srhv_in_stage imports this package.
package srhv_pkg;

    localparam int unsigned MIN_RECORD_LEN = 4 + 2 + 2 + 4 + 8 + 4 + 2 + 2;
    localparam int unsigned KEY_LEN_MAX    = 128;
    localparam int unsigned CFG_INDEX_W    = 2;

    localparam logic [31:0] MIN_RECORD_LEN_W = 32'(MIN_RECORD_LEN);
    localparam logic [15:0] KEY_LEN_MAX_W    = 16'(KEY_LEN_MAX);

    localparam logic [16:0] CAP_OFFER      = 17'(8 * 1024);
    localparam logic [16:0] CAP_MANIFEST   = 17'(64 * 1024);
    localparam logic [16:0] CAP_MIRROR     = 17'(8 * 1024);
    localparam logic [16:0] CAP_MIRROR_SET = 17'(16 * 1024);

    typedef enum logic [1:0] {
        KIND_OFFER      = 2'd0,
        KIND_MANIFEST   = 2'd1,
        KIND_MIRROR     = 2'd2,
        KIND_MIRROR_SET = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_LEN    = 2'd0,
        CFG_MAGIC      = 2'd1,
        CFG_VERSION    = 2'd2,
        CFG_FIRST_TYPE = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_TYPE    = 3'd4,
        ST_SIZE        = 3'd5,
        ST_TRAILING    = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        SEC_MAGIC  = 4'd0,
        SEC_VER    = 4'd1,
        SEC_TYPE   = 4'd2,
        SEC_FLAGS  = 4'd3,
        SEC_EXP    = 4'd4,
        SEC_PLEN   = 4'd5,
        SEC_PAY    = 4'd6,
        SEC_SLEN   = 4'd7,
        SEC_SIGNER = 4'd8,
        SEC_GLEN   = 4'd9,
        SEC_SIG    = 4'd10,
        SEC_DONE   = 4'd11,
        SEC_STOP   = 4'd12
    } section_t;

    typedef struct packed {
        logic [31:0] max_record_len;
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [15:0] first_type_code;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_record_len:  32'd131072,
        magic_word:      32'd0,
        format_version:  16'd1,
        first_type_code: 16'd1
    };

    typedef struct packed {
        status_t     status;
        logic [1:0]  record_kind;
        logic        kind_valid;
        logic [31:0] flag_bits;
        logic [63:0] expiry_time;
        logic [16:0] payload_length;
        logic [7:0]  signer_length;
        logic [7:0]  signature_length;
    } result_t;

    function automatic logic [16:0] payload_cap(input logic [1:0] kind);
        logic [16:0] cap;
        case (kind)
            KIND_OFFER:    cap = CAP_OFFER;
            KIND_MANIFEST: cap = CAP_MANIFEST;
            KIND_MIRROR:   cap = CAP_MIRROR;
            default:       cap = CAP_MIRROR_SET;
        endcase
        return cap;
    endfunction

endpackage

// ===== rtl/core/srhv_in_stage.sv =====
// Input register stage of the validator: holds one accepted byte until the parser takes it.
// Depends on nothing but the clock and reset.
module srhv_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       consume,
    output logic       hold_valid,
    output logic [7:0] hold_byte,
    output logic       hold_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       take;

    assign in_ready = !valid_reg || consume;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;
    assign hold_last  = last_reg;

endmodule

// ===== rtl/core/srhv_parse.sv =====
// Record parser: per-byte section stepping, field capture and the final status decision.
// Depends on srhv_pkg for the section, status, config and result types.
module srhv_parse
    import srhv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] step_byte,
    input  logic       step_last,
    output logic       res_valid,
    output result_t    res
);

    logic [31:0] count_reg, count_next;
    section_t    sec_reg, sec_next;
    logic [16:0] rem_reg, rem_next;
    logic [63:0] shift_reg, shift_next;
    status_t     err_reg, err_next;
    logic        kv_reg, kv_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] flags_reg, flags_next;
    logic [63:0] expiry_reg, expiry_next;
    logic [16:0] pend_reg, pend_next;
    logic [16:0] okpay_reg, okpay_next;
    logic [7:0]  oksigner_reg, oksigner_next;
    logic [7:0]  oksig_reg, oksig_next;

    logic [63:0] fs;
    logic        field_done;
    logic        rem_one;
    logic [1:0]  magic_idx;
    logic [7:0]  magic_byte;
    logic [15:0] v16;
    logic [31:0] v32;
    logic [16:0] type_diff;
    logic        len16_ok;
    status_t     status;

    assign fs         = {step_byte, shift_reg[63:8]};
    assign rem_one    = (rem_reg == 17'd1);
    assign magic_idx  = 2'd0 - rem_reg[1:0];
    assign magic_byte = cfg.magic_word[8*magic_idx +: 8];
    assign v16        = fs[63:48];
    assign v32        = fs[63:32];
    assign type_diff  = {1'b0, v16} - {1'b0, cfg.first_type_code};
    assign len16_ok   = (v16 != 16'd0) && (v16 <= KEY_LEN_MAX_W);

    always_comb
    begin
        count_next    = (count_reg == '1) ? count_reg : count_reg + 32'd1;
        sec_next      = sec_reg;
        rem_next      = rem_reg;
        shift_next    = shift_reg;
        err_next      = err_reg;
        kv_next       = kv_reg;
        kind_next     = kind_reg;
        flags_next    = flags_reg;
        expiry_next   = expiry_reg;
        pend_next     = pend_reg;
        okpay_next    = okpay_reg;
        oksigner_next = oksigner_reg;
        oksig_next    = oksig_reg;
        field_done    = 1'b0;

        case (sec_reg)
            SEC_MAGIC:
            begin
                if (step_byte != magic_byte)
                begin
                    err_next = ST_BAD_MAGIC;
                    sec_next = SEC_STOP;
                    rem_next = '0;
                end
                else if (rem_one)
                begin
                    sec_next   = SEC_VER;
                    rem_next   = 17'd2;
                    shift_next = '0;
                end
                else
                begin
                    rem_next = rem_reg - 17'd1;
                end
            end
            SEC_VER, SEC_TYPE, SEC_FLAGS, SEC_EXP, SEC_PLEN, SEC_SLEN, SEC_GLEN:
            begin
                shift_next = fs;
                rem_next   = rem_reg - 17'd1;
                field_done = rem_one;
            end
            SEC_PAY:
            begin
                rem_next = rem_reg - 17'd1;
                if (rem_one)
                begin
                    okpay_next = pend_reg;
                    sec_next   = SEC_SLEN;
                    rem_next   = 17'd2;
                    shift_next = '0;
                end
            end
            SEC_SIGNER:
            begin
                rem_next = rem_reg - 17'd1;
                if (rem_one)
                begin
                    oksigner_next = pend_reg[7:0];
                    sec_next      = SEC_GLEN;
                    rem_next      = 17'd2;
                    shift_next    = '0;
                end
            end
            SEC_SIG:
            begin
                rem_next = rem_reg - 17'd1;
                if (rem_one)
                begin
                    oksig_next = pend_reg[7:0];
                    sec_next   = SEC_DONE;
                    rem_next   = '0;
                    shift_next = '0;
                end
            end
            SEC_DONE:
            begin
                err_next = ST_TRAILING;
                sec_next = SEC_STOP;
                rem_next = '0;
            end
            default:
            begin
            end
        endcase

        // A completed field is checked here; a failure parks the parser until the last byte.
        if (field_done)
        begin
            case (sec_reg)
                SEC_VER:
                begin
                    if (v16 != cfg.format_version)
                    begin
                        err_next = ST_BAD_VERSION;
                        sec_next = SEC_STOP;
                        rem_next = '0;
                    end
                    else
                    begin
                        sec_next   = SEC_TYPE;
                        rem_next   = 17'd2;
                        shift_next = '0;
                    end
                end
                SEC_TYPE:
                begin
                    if (type_diff[16] || (type_diff[15:0] > 16'd3))
                    begin
                        err_next = ST_BAD_TYPE;
                        sec_next = SEC_STOP;
                        rem_next = '0;
                    end
                    else
                    begin
                        kv_next    = 1'b1;
                        kind_next  = type_diff[1:0];
                        sec_next   = SEC_FLAGS;
                        rem_next   = 17'd4;
                        shift_next = '0;
                    end
                end
                SEC_FLAGS:
                begin
                    flags_next = fs[63:32];
                    sec_next   = SEC_EXP;
                    rem_next   = 17'd8;
                    shift_next = '0;
                end
                SEC_EXP:
                begin
                    expiry_next = fs;
                    sec_next    = SEC_PLEN;
                    rem_next    = 17'd4;
                    shift_next  = '0;
                end
                SEC_PLEN:
                begin
                    if (v32 > {15'd0, payload_cap(kind_reg)})
                    begin
                        err_next = ST_SIZE;
                        sec_next = SEC_STOP;
                        rem_next = '0;
                    end
                    else if (v32 == 32'd0)
                    begin
                        okpay_next = '0;
                        sec_next   = SEC_SLEN;
                        rem_next   = 17'd2;
                        shift_next = '0;
                    end
                    else
                    begin
                        pend_next  = v32[16:0];
                        sec_next   = SEC_PAY;
                        rem_next   = v32[16:0];
                        shift_next = '0;
                    end
                end
                SEC_SLEN, SEC_GLEN:
                begin
                    if (!len16_ok)
                    begin
                        err_next = ST_SIZE;
                        sec_next = SEC_STOP;
                        rem_next = '0;
                    end
                    else
                    begin
                        pend_next  = {1'b0, v16};
                        sec_next   = (sec_reg == SEC_SLEN) ? SEC_SIGNER : SEC_SIG;
                        rem_next   = {1'b0, v16};
                        shift_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Whole-length checks win over anything found while parsing.
    always_comb
    begin
        res    = '0;
        status = ST_OK;
        if ((cfg.max_record_len == 32'd0) || (count_next > cfg.max_record_len))
        begin
            res.status = ST_SIZE;
        end
        else if (count_next < MIN_RECORD_LEN_W)
        begin
            res.status = ST_SHORT;
        end
        else
        begin
            if (err_next != ST_OK)
            begin
                status = err_next;
            end
            else
            begin
                case (sec_next)
                    SEC_DONE:                    status = ST_OK;
                    SEC_PAY, SEC_SIGNER, SEC_SIG: status = ST_SIZE;
                    default:                     status = ST_SHORT;
                endcase
            end
            res.status           = status;
            res.record_kind      = kv_next ? kind_next : 2'd0;
            res.kind_valid       = kv_next;
            res.flag_bits        = flags_next;
            res.expiry_time      = expiry_next;
            res.payload_length   = okpay_next;
            res.signer_length    = oksigner_next;
            res.signature_length = oksig_next;
        end
    end

    assign res_valid = step && step_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sec_reg      <= SEC_MAGIC;
            rem_reg      <= 17'd4;
            shift_reg    <= '0;
            err_reg      <= ST_OK;
            kv_reg       <= 1'b0;
            kind_reg     <= '0;
            flags_reg    <= '0;
            expiry_reg   <= '0;
            pend_reg     <= '0;
            okpay_reg    <= '0;
            oksigner_reg <= '0;
            oksig_reg    <= '0;
        end
        else if (step && step_last)
        begin
            // The record is finished: start over at the magic.
            count_reg    <= '0;
            sec_reg      <= SEC_MAGIC;
            rem_reg      <= 17'd4;
            shift_reg    <= '0;
            err_reg      <= ST_OK;
            kv_reg       <= 1'b0;
            kind_reg     <= '0;
            flags_reg    <= '0;
            expiry_reg   <= '0;
            pend_reg     <= '0;
            okpay_reg    <= '0;
            oksigner_reg <= '0;
            oksig_reg    <= '0;
        end
        else if (step)
        begin
            count_reg    <= count_next;
            sec_reg      <= sec_next;
            rem_reg      <= rem_next;
            shift_reg    <= shift_next;
            err_reg      <= err_next;
            kv_reg       <= kv_next;
            kind_reg     <= kind_next;
            flags_reg    <= flags_next;
            expiry_reg   <= expiry_next;
            pend_reg     <= pend_next;
            okpay_reg    <= okpay_next;
            oksigner_reg <= oksigner_next;
            oksig_reg    <= oksig_next;
        end
    end

endmodule

// ===== rtl/core/srhv_out_stage.sv =====
// Result register of the validator: holds one result transaction until the consumer takes it.
// Depends on srhv_pkg for the result type.
module srhv_out_stage
    import srhv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    slot_free,
    output result_t held_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign held_res  = res_reg;

endmodule

// ===== rtl/core/signed_record_header_validator_core.sv =====
// Top level of the signed record header validator: config registers, input stage,
// parser and result register. Depends on srhv_pkg, srhv_in_stage, srhv_parse, srhv_out_stage.
//
// The block takes one record byte per cycle on the input channel and gives one result
// transaction for each byte marked last_byte; that byte passes through the input register and then
// the result register, and every byte is checked by a single pass of logic between those
// two registers, so bytes stream at one per cycle for as long as the consumer keeps up; a
// result waiting in the result register stalls the input only when the next last byte arrives.
// Configuration registers may be rewritten only while no record is in flight.
module signed_record_header_validator_core
    import srhv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [1:0]             record_kind,
    output logic                   kind_valid,
    output logic [31:0]            flag_bits,
    output logic [63:0]            expiry_time,
    output logic [16:0]            payload_length,
    output logic [7:0]             signer_length,
    output logic [7:0]             signature_length
);

    cfg_t    cfg_reg;
    logic    hold_valid;
    logic [7:0] hold_byte;
    logic    hold_last;
    logic    consume;
    logic    slot_free;
    logic    res_valid;
    result_t res;
    result_t held_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_LEN:    cfg_reg.max_record_len  <= cfg_data;
                CFG_MAGIC:      cfg_reg.magic_word      <= cfg_data;
                CFG_VERSION:    cfg_reg.format_version  <= cfg_data[15:0];
                CFG_FIRST_TYPE: cfg_reg.first_type_code <= cfg_data[15:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A byte moves into the parser unless it would produce a result with nowhere to go.
    assign consume = hold_valid && (!hold_last || slot_free);

    srhv_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .consume    (consume),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .hold_last  (hold_last)
    );

    srhv_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (consume),
        .step_byte (hold_byte),
        .step_last (hold_last),
        .res_valid (res_valid),
        .res       (res)
    );

    srhv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_res  (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .slot_free (slot_free),
        .held_res  (held_res)
    );

    assign status           = held_res.status;
    assign record_kind      = held_res.record_kind;
    assign kind_valid       = held_res.kind_valid;
    assign flag_bits        = held_res.flag_bits;
    assign expiry_time      = held_res.expiry_time;
    assign payload_length   = held_res.payload_length;
    assign signer_length    = held_res.signer_length;
    assign signature_length = held_res.signature_length;

endmodule

// ===== rtl/core/srhv_checker.sv =====
// Port-level assertions for the validator and the bind that attaches them to the top level.
// Depends on srhv_pkg for the status codes.
module srhv_checker
    import srhv_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [2:0]             status,
    input logic [1:0]             record_kind,
    input logic                   kind_valid,
    input logic [31:0]            flag_bits,
    input logic [63:0]            expiry_time,
    input logic [16:0]            payload_length,
    input logic [7:0]             signer_length,
    input logic [7:0]             signature_length
);

    // A stalled result transaction keeps its status, payload length and signature length.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(payload_length) && $stable(signature_length))
        else $error("result changed while stalled");

    // A clean record has an accepted type and both key lengths.
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |->
            kind_valid && (signer_length != 8'd0) && (signature_length != 8'd0))
        else $error("ok status without complete fields");

    // A magic mismatch happens before any field is parsed.
    a_magic_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD_MAGIC) |->
            !kind_valid && (flag_bits == 32'd0) && (expiry_time == 64'd0))
        else $error("fields present after magic mismatch");

    // No accepted payload is ever above the largest per-kind cap, and the kind reads zero unless valid.
    a_payload_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_length <= CAP_MANIFEST) && (kind_valid || record_kind == 2'd0))
        else $error("payload length or kind out of range");

endmodule

bind signed_record_header_validator_core srhv_checker u_srhv_checker (.*);
